### hdl/rpn_stack_alu_core_macros.svh
// Assertion macros shared by the calculator RTL.
// Depends on nothing; included by the top level only.
`ifndef RPN_STACK_ALU_CORE_MACROS_SVH
`define RPN_STACK_ALU_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define RSA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define RSA_ASSERT_IMP(label, clk, rst, a, c)
`define RSA_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

### hdl/rsa_pkg.sv
// Shared types and codes for the calculator core.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package rsa_pkg;
  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
    OP_PTOP = 4'd5, OP_PALL = 4'd6, OP_DUP = 4'd7, OP_SWAP = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_FULL = 3'd3, ST_DIVZ = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP1, S_POP2, S_READ, S_EXEC, S_DIV, S_DIVFIN, S_WRITE, S_WRITE2,
    S_PREAD, S_PWAIT, S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;     // capture operand_value
    logic       rd_req;      // read entry at count - 1 - rd_off
    logic       rd_to_a;     // 1: read data goes to operand a, else b
    logic       dec;         // count - 1
    logic       inc;         // count + 1, writing wr_sel
    logic [1:0] wr_sel;      // 0 input, 1 result, 2 operand a, 3 operand b
    logic       alu_go;      // compute add/sub/mul result or take the quotient
    logic       div_start;
    logic       out_load;    // load output register
    logic       out_from_rd; // printed value from read data
    status_t    out_status;
    logic       out_last;
    logic       rd_off_clr;
    logic       rd_off_inc;
  } rsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic ovf;        // add/sub/mul overflow
    logic divz;
    logic div_ovf;
    logic div_done;
    logic walk_end;   // next print would exceed count or the result limit
    logic out_busy;
  } rsa_stat_t;
endpackage
`default_nettype wire

### hdl/rsa_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Uses no package; instantiated by the datapath.
`default_nettype none
module rsa_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] rem, quo, dvs;
  logic [5:0]  cnt;
  logic        neg, busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  // Shift-subtract restoring division on magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= dividend[31] ? -dividend : dividend;
        dvs  <= divisor[31] ? -divisor : divisor;
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -quo : quo;
endmodule
`default_nettype wire

### hdl/rsa_datapath.sv
// Stack memory, count, operand registers, ALU, divider and output register.
// Depends on rsa_pkg and rsa_div.
`default_nettype none
module rsa_datapath #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rsa_pkg::rsa_cmd_t   cmd,
  input  wire rsa_pkg::op_t        op,
  input  wire logic [31:0]         operand_value,
  input  wire logic                out_ready,
  output rsa_pkg::rsa_stat_t       stat,
  output logic                     out_valid,
  output logic [31:0]              result_value,
  output logic                     has_value,
  output logic [2:0]               status,
  output logic                     last
);
  import rsa_pkg::*;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data, opa, opb, inval, res, wdat;
  logic [CW-1:0] count;
  logic [4:0]  rd_off;
  logic [CW-1:0] rd_idx;
  logic [32:0] sum;
  logic [63:0] prod;
  logic        ovf;
  logic        div_done;
  logic [31:0] quo;

  assign rd_idx = count - CW'(1) - CW'(rd_off);

  // Stack memory: one write port, registered read into the print and operand registers
  always_ff @(posedge clk) begin
    if (cmd.inc) mem[count[AW-1:0]] <= wdat;
    if (cmd.rd_req) begin
      rd_data <= mem[rd_idx[AW-1:0]];
      if (cmd.rd_to_a) opa <= mem[rd_idx[AW-1:0]];
      else opb <= mem[rd_idx[AW-1:0]];
    end
  end

  always_comb begin
    unique case (cmd.wr_sel)
      2'd0:    wdat = inval;
      2'd1:    wdat = res;
      2'd2:    wdat = opa;
      default: wdat = opb;
    endcase
  end

  // Count and walk offset
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_off <= '0;
    end else begin
      if (cmd.dec) count <= count - CW'(1);
      else if (cmd.inc) count <= count + CW'(1);
      if (cmd.rd_off_clr) rd_off <= '0;
      else if (cmd.rd_off_inc) rd_off <= rd_off + 5'd1;
    end
  end

  // Capture the push value; a is the first popped (top), b the second
  always_ff @(posedge clk) begin
    if (cmd.load_in) inval <= operand_value;
  end

  // Second minus top, or second plus top, with one guard bit
  assign sum = (op == OP_SUB) ? ({opb[31], opb} - {opa[31], opa})
                              : ({opb[31], opb} + {opa[31], opa});
  assign prod = $signed(opb) * $signed(opa);

  // Add/sub/mul or quotient, result registered
  always_ff @(posedge clk) begin
    if (cmd.alu_go) begin
      unique case (op)
        OP_ADD, OP_SUB: begin
          res <= sum[31:0];
          ovf <= sum[32] ^ sum[31];
        end
        OP_MUL: begin
          res <= prod[31:0];
          ovf <= (prod[63:31] != {33{1'b0}}) && (prod[63:31] != {33{1'b1}});
        end
        default: begin
          res <= quo;
          ovf <= 1'b0;
        end
      endcase
    end
  end

  rsa_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(opb), .divisor(opa),
    .done(div_done), .quotient(quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.out_load) begin
      result_value <= cmd.out_from_rd ? rd_data : '0;
      has_value    <= cmd.out_from_rd;
      status       <= cmd.out_status;
      last         <= cmd.out_last;
    end
  end

  assign stat.empty    = (count == '0);
  assign stat.full     = (count >= CW'(STACK_DEPTH));
  assign stat.ovf      = ovf;
  assign stat.divz     = (opa == '0);
  assign stat.div_ovf  = (opa == 32'hFFFF_FFFF) && (opb == 32'h8000_0000);
  assign stat.div_done = div_done;
  assign stat.walk_end = (32'(rd_off) + 32'd1 >= 32'(count)) ||
                         (rd_off == 5'(MAX_RESULTS - 1));
  assign stat.out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire

### hdl/rsa_ctrl.sv
// Sequencer for the calculator: decodes each request into datapath steps.
// Depends on rsa_pkg.
`default_nettype none
module rsa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rsa_pkg::op_t       op_in,
  output rsa_pkg::op_t            op,
  input  wire rsa_pkg::rsa_stat_t stat,
  output rsa_pkg::rsa_cmd_t       cmd
);
  import rsa_pkg::*;
  state_t  state, state_next;
  op_t     op_next;
  status_t pend, pend_next;      // status of pending result
  logic    pend_last, pend_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_PUSH;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
    pend <= pend_next;
    pend_last <= pend_last_next;
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    pend_next  = pend;
    pend_last_next = pend_last;
    cmd        = '0;
    cmd.out_status = ST_OK;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next = op_in;
          cmd.load_in = 1'b1;
          cmd.rd_off_clr = 1'b1;
          pend_last_next = 1'b1;
          pend_next = ST_OK;
          priority case (op_in)
            OP_PUSH: state_next = S_WRITE;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DUP, OP_SWAP: state_next = S_POP1;
            OP_PTOP, OP_PALL: state_next = S_PREAD;
            default: state_next = S_OUT;
          endcase
        end
      end
      // Pop the top into operand a
      S_POP1: begin
        if (stat.empty) begin
          pend_next = ST_UNDER;
          state_next = S_OUT;
        end else begin
          cmd.rd_req = 1'b1;
          cmd.rd_to_a = 1'b1;
          cmd.dec = 1'b1;
          state_next = (op == OP_DUP) ? S_READ : S_POP2;
        end
      end
      // Pop the second into operand b
      S_POP2: begin
        if (stat.empty) begin
          pend_next = ST_UNDER;
          state_next = S_OUT;
        end else begin
          cmd.rd_req = 1'b1;
          cmd.dec = 1'b1;
          state_next = S_READ;
        end
      end
      // Operand registers settle
      S_READ: begin
        if (op == OP_DUP || op == OP_SWAP) state_next = S_WRITE;
        else if (op == OP_DIV) begin
          if (stat.divz) begin
            pend_next = ST_DIVZ;
            state_next = S_OUT;
          end else if (stat.div_ovf) begin
            pend_next = ST_OVER;
            state_next = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end
        end else begin
          cmd.alu_go = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_DIVFIN;
      end
      S_DIVFIN: begin
        cmd.alu_go = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.ovf) begin
          pend_next = ST_OVER;
          state_next = S_OUT;
        end else begin
          cmd.inc = 1'b1;
          cmd.wr_sel = 2'd1;
          state_next = S_OUT;
        end
      end
      // Push input, or first write of dup/swap
      S_WRITE: begin
        if (op == OP_PUSH) begin
          if (stat.full) pend_next = ST_FULL;
          else begin
            cmd.inc = 1'b1;
            cmd.wr_sel = 2'd0;
          end
          state_next = S_OUT;
        end else begin
          cmd.inc = 1'b1;
          cmd.wr_sel = 2'd2;
          state_next = S_WRITE2;
        end
      end
      S_WRITE2: begin
        if (op == OP_DUP) begin
          if (stat.full) pend_next = ST_FULL;
          else begin
            cmd.inc = 1'b1;
            cmd.wr_sel = 2'd2;
          end
        end else begin
          cmd.inc = 1'b1;
          cmd.wr_sel = 2'd3;
        end
        state_next = S_OUT;
      end
      // Read next element to print
      S_PREAD: begin
        if (stat.empty) begin
          pend_next = ST_UNDER;
          state_next = S_OUT;
        end else if (!stat.out_busy) begin
          cmd.rd_req = 1'b1;
          pend_last_next = (op == OP_PTOP) || stat.walk_end;
          state_next = S_PWAIT;
        end
      end
      S_PWAIT: begin
        cmd.out_load = 1'b1;
        cmd.out_from_rd = 1'b1;
        cmd.out_last = pend_last;
        if (pend_last) state_next = S_IDLE;
        else begin
          cmd.rd_off_inc = 1'b1;
          state_next = S_PREAD;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_status = pend;
          cmd.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hdl/rpn_stack_alu_core.sv
// Top level of the reverse-Polish calculator core.
// Depends on rsa_pkg, rsa_ctrl, rsa_datapath and the assertion macro header.
//
// Usage:
//   Requests enter on in_valid/in_ready with operation and operand_value.
//   Results leave on out_valid/out_ready with result_value, has_value,
//   status and last; last marks the final result of a request.
//   One request is worked at a time; divide runs the 32-step
//   shift-subtract divider.
//   Print all gives up to 16 results, top first, each read through the
//   stack memory's registered read port.
//   Results sit in one output register; the next request is taken as soon
//   as its result is loaded, even while that result waits for out_ready.
//   A stalled receiver holds the output register and pauses the sequencer
//   before it loads another result.
//   Reset empties the stack (count to zero) and drops any pending result;
//   the memory itself is not cleared.
`default_nettype none
`include "rpn_stack_alu_core_macros.svh"
module rpn_stack_alu_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  operation,
  input  wire logic [31:0] operand_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_value,
  output logic             has_value,
  output logic [2:0]       status,
  output logic             last
);
  import rsa_pkg::*;
  rsa_cmd_t  cmd;
  rsa_stat_t stat;
  op_t       op;

  rsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op_in(op_t'(operation)), .op(op), .stat(stat), .cmd(cmd)
  );

  rsa_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .op(op), .operand_value(operand_value),
    .out_ready(out_ready), .stat(stat), .out_valid(out_valid),
    .result_value(result_value), .has_value(has_value), .status(status),
    .last(last)
  );

  `RSA_ASSERT_IMP(a_no_inc_dec, clk, rst, 1'b1, !(cmd.inc && cmd.dec))
  `RSA_ASSERT_IMP(a_no_load_busy, clk, rst, cmd.out_load, !stat.out_busy)
  `RSA_ASSERT_IMP(a_nohas_status, clk, rst, out_valid && has_value, status == ST_OK)
endmodule
`default_nettype wire
